// ===== rtl/mahosc_pkg.sv =====
package mahosc_pkg;

    localparam logic REQ_MIDI = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [7:0] NOTE_ON_STATUS = 8'd144;
    localparam logic [7:0] NOTE_RESET     = 8'd69;
    localparam logic [2:0] GAIN_RESET     = 3'd1;

    localparam int unsigned NOTE_COUNT = 256;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // 2^(k/12) in Q16
    localparam int unsigned SEMITONE_Q16 [12] = '{
        65536, 69433, 73562, 77936, 82570, 87480,
        92682, 98193, 104032, 110218, 116772, 123715
    };

    typedef struct packed {
        logic midi_wr;   // MIDI transaction accepted
        logic start;     // tick accepted: latch increment, clear accumulators
        logic issue;     // process one harmonic
        logic div;       // scale the sum by the harmonic count
        logic load_out;  // move the sample into the output register
    } t_cmd;

    typedef struct packed {
        logic last_harm;
        logic pipe_busy;
    } t_status;

    // sin(pi/2 * p / 2^qbits) in Q1.15, Taylor series in Q30
    function automatic logic [15:0] quarter_sine(input longint unsigned p,
                                                 input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        x  = (p * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        r  = (s + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                      input int unsigned bits);
        int unsigned qbits;
        int unsigned quad;
        int unsigned q;
        int unsigned p;
        logic [15:0] v;
        qbits = bits - 2;
        quad  = i >> qbits;
        q     = i & ((32'd1 << qbits) - 1);
        p     = ((quad & 1) != 0) ? ((32'd1 << qbits) - q) : q;
        v     = quarter_sine(64'(p), qbits);
        return ((quad & 2) != 0) ? -$signed(v) : $signed(v);
    endfunction

    // 55 * 2^(k/12) scaled so that a division by the sample rate gives turns in Q32
    function automatic longint unsigned note_num(input int unsigned n);
        int unsigned d;
        int unsigned oct;
        int unsigned k;
        d   = (n & 32'd255) + 3;
        oct = d / 12 + 13;
        k   = d % 12;
        return (64'd55 * 64'(SEMITONE_Q16[k])) << oct;
    endfunction

endpackage

// ===== rtl/mahosc_req_if.sv =====
interface mahosc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] midi_word;

    modport source (output valid, output req_type, output midi_word, input ready);
    modport sink   (input valid, input req_type, input midi_word, output ready);
endinterface

// ===== rtl/mahosc_smp_if.sv =====
interface mahosc_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/mahosc_ctrl.sv =====
module mahosc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_type,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mahosc_pkg::t_cmd    o_cmd,
    input  mahosc_pkg::t_status i_st
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_WAIT = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_type == mahosc_pkg::REQ_TICK) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RUN;
                    end else begin
                        o_cmd.midi_wr = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_st.last_harm) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free or being drained
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ===== rtl/mahosc_datapath.sv =====
module mahosc_datapath #(
    parameter int HARMONIC_COUNT  = 10,
    parameter int SAMPLE_RATE_HZ  = 44100,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mahosc_pkg::t_cmd    i_cmd,
    output mahosc_pkg::t_status o_st,
    input  logic [23:0]         i_midi_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    output logic signed [15:0]  o_sample
);

    localparam int HARM_W   = $clog2(HARMONIC_COUNT);
    localparam int SINE_LEN = 1 << SINE_TABLE_BITS;
    localparam int SH_RAW   = $clog2(7 * (HARMONIC_COUNT - 1) + 1);
    localparam int SH_W     = (SH_RAW < 4) ? 4 : SH_RAW;
    localparam int SUM_W    = 17 + $clog2(HARMONIC_COUNT);
    localparam int DIV_K    = SUM_W + $clog2(HARMONIC_COUNT) + 1;
    localparam int PROD_W   = SUM_W + DIV_K;
    localparam logic [DIV_K-1:0] RECIP =
        DIV_K'(((64'd1 << DIV_K) + 64'(HARMONIC_COUNT) - 64'd1) / 64'(HARMONIC_COUNT));

    // constant tables
    logic signed [15:0] w_sine_tab [SINE_LEN];
    logic        [31:0] w_inc_tab  [mahosc_pkg::NOTE_COUNT];

    for (genvar g = 0; g < SINE_LEN; g++) begin : g_sine
        assign w_sine_tab[g] = mahosc_pkg::sine_entry(g, SINE_TABLE_BITS);
    end

    for (genvar g = 0; g < mahosc_pkg::NOTE_COUNT; g++) begin : g_inc
        assign w_inc_tab[g] = 32'((mahosc_pkg::note_num(g) + 64'(SAMPLE_RATE_HZ / 2))
                                  / 64'(SAMPLE_RATE_HZ));
    end

    logic [2:0]                 r_gain;
    logic [7:0]                 r_note;
    logic [31:0]                r_phase [HARMONIC_COUNT];
    logic [HARM_W-1:0]          r_harm;
    logic                       r_a_vld;
    logic                       r_b_vld;
    logic signed [SUM_W-1:0]    r_sum;
    logic [31:0]                r_inc;
    logic [31:0]                r_step;
    logic [SH_W-1:0]            r_shacc;
    logic [SINE_TABLE_BITS-1:0] r_a_idx;
    logic [SH_W-1:0]            r_a_sh;
    logic signed [15:0]         r_b_sine;
    logic [SH_W-1:0]            r_b_sh;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;
    logic signed [15:0]         r_sample;

    logic [3:0]                 w_sh_cap;
    logic signed [15:0]         w_term;
    logic [SUM_W-1:0]           w_mag;
    logic [16:0]                w_q;
    logic [16:0]                w_res;

    // shifts of 15 and more all leave the sign only
    assign w_sh_cap = (r_b_sh > SH_W'(15)) ? 4'd15 : r_b_sh[3:0];
    assign w_term   = r_b_sine >>> w_sh_cap;
    assign w_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_q      = r_prod[DIV_K +: 17];
    assign w_res    = r_neg ? (~w_q + 17'd1) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= mahosc_pkg::GAIN_RESET;
            r_note  <= mahosc_pkg::NOTE_RESET;
            r_harm  <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_sum   <= '0;
            for (int k = 0; k < HARMONIC_COUNT; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (i_cmd.midi_wr && i_midi_word[7:0] == mahosc_pkg::NOTE_ON_STATUS) begin
                r_note <= i_midi_word[15:8];
            end
            if (i_cmd.start) begin
                r_harm <= '0;
                r_sum  <= '0;
            end else if (i_cmd.issue) begin
                r_harm          <= r_harm + HARM_W'(1);
                r_phase[r_harm] <= r_phase[r_harm] + r_step;
            end
            r_a_vld <= i_cmd.issue;
            r_b_vld <= r_a_vld;
            if (r_b_vld) begin
                r_sum <= r_sum + SUM_W'(w_term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_inc   <= w_inc_tab[r_note];
            r_step  <= '0;
            r_shacc <= '0;
        end else if (i_cmd.issue) begin
            r_step  <= r_step + r_inc;
            r_shacc <= r_shacc + SH_W'(r_gain);
        end
        r_a_idx  <= r_phase[r_harm][31 -: SINE_TABLE_BITS];
        r_a_sh   <= r_shacc;
        r_b_sine <= w_sine_tab[r_a_idx];
        r_b_sh   <= r_a_sh;
        if (i_cmd.div) begin
            // truncating division by the harmonic count via reciprocal
            r_prod <= PROD_W'(w_mag) * PROD_W'(RECIP);
            r_neg  <= r_sum[SUM_W-1];
        end
        if (i_cmd.load_out) begin
            r_sample <= $signed(w_res[15:0]);
        end
    end

    assign o_st.last_harm = (r_harm == HARM_W'(HARMONIC_COUNT - 1));
    assign o_st.pipe_busy = r_a_vld | r_b_vld;
    assign o_sample       = r_sample;

endmodule

// ===== rtl/midi_additive_harmonic_oscillator.sv =====
// Additive harmonic oscillator bank driven by MIDI note-on messages.
// Input channel i_req: req_type 0 carries a MIDI message in midi_word (status
// in bits 7:0, note in 15:8); only status 144 changes anything, it selects the
// note. req_type 1 is a sample tick and yields one Q1.15 sample on o_smp.
// Config: i_cfg_we/i_cfg_wdata write the rolloff shift (harmonic j is scaled
// by 2^-(shift*j)); write it only while the block is idle.
// Sequence: a MIDI transaction is taken while the block is idle and leaves it idle.
// A tick occupies the block: the accept step, one harmonic per cycle through the
// shared sine table, a wait while the two-stage pipeline drains, the reciprocal
// multiply and the load of the output register, after which the sample is valid.
// Stall: the result sits in an output register; MIDI transactions are still
// taken while it waits, and the next tick runs and then holds its result
// until the pending sample is taken.
// Reset (i_rst_n low at a clock edge): note 69 (440 Hz), shift 1, all phases
// zero, output empty.
module midi_additive_harmonic_oscillator #(
    parameter int HARMONIC_COUNT  = 10,
    parameter int SAMPLE_RATE_HZ  = 44100,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mahosc_req_if.sink    i_req,
    mahosc_smp_if.source  o_smp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_wdata
);

    mahosc_pkg::t_cmd    w_cmd;
    mahosc_pkg::t_status w_st;
    logic                w_in_ready;
    logic                w_out_valid;
    logic signed [15:0]  w_sample;

    mahosc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_type   (i_req.req_type),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_smp.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .i_st        (w_st)
    );

    mahosc_datapath #(
        .HARMONIC_COUNT  (HARMONIC_COUNT),
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_midi_word (i_req.midi_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sample    (w_sample)
    );

    assign i_req.ready      = w_in_ready;
    assign o_smp.valid      = w_out_valid;
    assign o_smp.sample_out = w_sample;

`ifndef SYNTHESIS
    // a MIDI transaction never produces a sample
    a_midi_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.req_type == mahosc_pkg::REQ_MIDI
            && !o_smp.valid |=> !o_smp.valid)
        else $error("sample produced by a MIDI transaction");

    // a tick occupies the block, so input is held off next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.req_type == mahosc_pkg::REQ_TICK
            |=> !i_req.ready)
        else $error("input ready right after a tick transaction");

    // a sample cannot appear in the cycle after a tick is accepted
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.req_type == mahosc_pkg::REQ_TICK
            && !o_smp.valid |=> !o_smp.valid)
        else $error("sample appeared too early after a tick");
`endif

endmodule
